// File: rtl/core/hab4_pkg.sv
// Shared widths, register codes, reset values and helper functions of the harvester load step.
`timescale 1ns / 1ps

package hab4_pkg;

  localparam int FRAC_BITS_DEF = 32;

  localparam int DATA_W    = 48;
  localparam int CFG_W     = 47;
  localparam int CFG_IDX_W = 4;
  localparam int SUM_W     = DATA_W + 2;

  // Shared multiplier: A is the wide operand, B is consumed in digits.
  localparam int MUL_A_W    = 56;
  localparam int MUL_B_W    = 48;
  localparam int MUL_DIG_W  = 16;
  localparam int MUL_DIGITS = MUL_B_W / MUL_DIG_W;
  localparam int DIG_CNT_W  = $clog2(MUL_DIGITS);
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  // floor(x / 3) = (x * DIV3_MAGIC) >> DIV_SHIFT, exact for x below 2^47.
  localparam int DIV_SHIFT = 48;
  localparam logic [MUL_B_W-1:0] DIV3_MAGIC = MUL_B_W'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);

  localparam int HIST_DEPTH = 4;
  localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
  localparam int PHASE_W    = 3;
  localparam logic [PHASE_W-1:0] PHASE_AB = PHASE_W'(HIST_DEPTH);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING_OVER_CAP    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RC               = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE            = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING_OVER_LENGTH = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_STIFFNESS     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TORSION_BASE         = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TORSION_SLOPE        = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_THRESHOLD      = 4'd7;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_COUPLING_OVER_CAP    = 47'd55476661077333;
  localparam logic [CFG_W-1:0] RST_INV_RC               = 47'd357913941333;
  localparam logic [CFG_W-1:0] RST_STEP_SIZE            = 47'd858993;
  localparam logic [CFG_W-1:0] RST_COUPLING_OVER_LENGTH = 47'd13314399;
  localparam logic [CFG_W-1:0] RST_LINEAR_STIFFNESS     = 47'd615898310246;
  localparam logic [CFG_W-1:0] RST_TORSION_BASE         = 47'd9835475108;
  localparam logic [CFG_W-1:0] RST_TORSION_SLOPE        = 47'd55898100000;
  localparam logic [CFG_W-1:0] RST_ANGLE_THRESHOLD      = 47'd749590350;

  typedef struct packed {
    logic [CFG_W-1:0] coupling_over_cap;
    logic [CFG_W-1:0] inv_rc;
    logic [CFG_W-1:0] step_size;
    logic [CFG_W-1:0] coupling_over_length;
    logic [CFG_W-1:0] linear_stiffness;
    logic [CFG_W-1:0] torsion_base;
    logic [CFG_W-1:0] torsion_slope;
    logic [CFG_W-1:0] angle_threshold;
  } cfg_regs_t;

  typedef struct packed {
    logic start;
    logic div_mode;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] result;
  } mul_rsp_t;

  // Clamp an exact sum to the 48-bit signed range.
  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    lo = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    if (x > hi) begin
      sat_sum = hi[DATA_W-1:0];
    end else if (x < lo) begin
      sat_sum = lo[DATA_W-1:0];
    end else begin
      sat_sum = x[DATA_W-1:0];
    end
  endfunction

  // Adams-Bashforth weights, oldest slot first.
  function automatic logic signed [7:0] ab4_coef(input logic [HIST_IDX_W-1:0] idx);
    case (idx)
      2'd0: ab4_coef = -8'sd9;
      2'd1: ab4_coef = 8'sd37;
      2'd2: ab4_coef = -8'sd59;
      2'd3: ab4_coef = 8'sd55;
      default: ab4_coef = 8'sd0;
    endcase
  endfunction

endpackage

// File: rtl/core/hab4_if.sv
// Handshake channel interfaces: motion beats in, load beats out, register writes.
`timescale 1ns / 1ps

interface hab4_motion_if;
  logic                               valid;
  logic                               ready;
  logic signed [hab4_pkg::DATA_W-1:0] velocity_y;
  logic signed [hab4_pkg::DATA_W-1:0] position_y;
  logic signed [hab4_pkg::DATA_W-1:0] angle_z;
  modport source (output valid, velocity_y, position_y, angle_z, input ready);
  modport sink (input valid, velocity_y, position_y, angle_z, output ready);
endinterface

interface hab4_load_if;
  logic                               valid;
  logic                               ready;
  logic signed [hab4_pkg::DATA_W-1:0] force_y;
  logic signed [hab4_pkg::DATA_W-1:0] moment_z;
  logic signed [hab4_pkg::DATA_W-1:0] voltage;
  modport source (output valid, force_y, moment_z, voltage, input ready);
  modport sink (input valid, force_y, moment_z, voltage, output ready);
endinterface

interface hab4_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [hab4_pkg::CFG_IDX_W-1:0]    index;
  logic [hab4_pkg::CFG_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/harvester_ab4_load_step.sv
// Top level of the harvester load step: sequencer, state and output register.
`timescale 1ns / 1ps

// One motion beat (vertical velocity, vertical position, rotation angle, all signed
// fixed point with FRAC_BITS fraction bits in 48 bits) gives one load beat: vertical
// force, moment about z and the harvester voltage after the step, each saturated to
// 48 bits. The first beat after reset clears the voltage, the next three take Euler
// steps that fill the derivative history, and every later beat takes a four-step
// Adams-Bashforth step. All products go through one shared multiplier that takes a
// 48-bit operand 16 bits at a time. A beat needs four or five products for the
// force and moment, three more on an Euler step, and on an Adams-Bashforth step
// four more plus a weighted sum of the four history slots. motion.ready is high
// only while the sequencer is idle; a finished result waits in the output register,
// so the next beat can be taken while the last one is unread. Registers are written
// through cfg; write them only while the block is idle, as the block itself does
// not enforce this. cfg.ready is always high and writes beyond the register list
// are dropped.
module harvester_ab4_load_step #(
  parameter int FRAC_BITS = hab4_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  hab4_motion_if.sink   motion,
  hab4_load_if.source   load,
  hab4_cfg_if.sink      cfg
);

  localparam int DW = hab4_pkg::DATA_W;
  localparam int SW = hab4_pkg::SUM_W;
  localparam int AW = hab4_pkg::MUL_A_W;
  localparam int BW = hab4_pkg::MUL_B_W;
  localparam int HW = hab4_pkg::HIST_IDX_W;
  localparam int HD = hab4_pkg::HIST_DEPTH;
  localparam int PH = hab4_pkg::PHASE_W;

  // 0.0225 in fixed point, rounded to nearest.
  localparam logic [DW-1:0] K0225 = DW'(((64'd9 << FRAC_BITS) + 64'd200) / 64'd400);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_H24   = 13'b0000000000010,
    S_COMBO = 13'b0000000000100,
    S_AB    = 13'b0000000001000,
    S_FA    = 13'b0000000010000,
    S_FB    = 13'b0000000100000,
    S_EU    = 13'b0000001000000,
    S_KLY   = 13'b0000010000000,
    S_FC    = 13'b0000100000000,
    S_KT    = 13'b0001000000000,
    S_MT    = 13'b0010000000000,
    S_MK    = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t                state;
  logic                  issued;
  logic [PH-1:0]         phase;
  logic signed [DW-1:0]  volt;
  logic signed [DW-1:0]  hist [HD];
  logic [HW-1:0]         cidx;
  logic                  out_valid;

  logic signed [DW-1:0]  vel;
  logic signed [DW-1:0]  pos;
  logic signed [DW-1:0]  ang;
  logic [DW-1:0]         absang;
  logic                  ab_mode;
  logic [HW-1:0]         fidx;
  logic signed [SW-1:0]  tmp;
  logic signed [DW-1:0]  fval;
  logic [BW-1:0]         h24;
  logic signed [AW-1:0]  combo;
  logic signed [DW-1:0]  kly;
  logic signed [DW-1:0]  kt;
  logic signed [DW-1:0]  force_val;
  logic signed [DW-1:0]  moment_val;
  logic signed [DW-1:0]  out_force;
  logic signed [DW-1:0]  out_moment;
  logic signed [DW-1:0]  out_voltage;

  hab4_pkg::cfg_regs_t   regs;
  hab4_pkg::mul_req_t    mul_req;
  hab4_pkg::mul_rsp_t    mul_rsp;
  logic signed [AW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic                  mul_state;
  logic                  mul_div;
  logic                  mul_done;

  logic signed [SW-1:0]  p_ext;
  logic signed [DW-1:0]  volt_sum;
  logic signed [DW-1:0]  f_new;
  logic signed [AW-1:0]  term;
  logic                  above;
  logic signed [DW:0]    ang_excess;
  logic                  out_free;

  hab4_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  hab4_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .a   (mul_a),
    .b   (mul_b),
    .rsp (mul_rsp)
  );

  assign motion.ready = (state == S_IDLE);
  assign load.valid   = out_valid;
  assign load.force_y  = out_force;
  assign load.moment_z = out_moment;
  assign load.voltage  = out_voltage;

  assign out_free = !out_valid || load.ready;
  assign mul_done = mul_rsp.done;

  // Rounded, saturated product widened for the exact sums that follow it.
  assign p_ext    = SW'(mul_rsp.result);
  assign volt_sum = hab4_pkg::sat_sum(SW'(volt) + p_ext);
  assign f_new    = hab4_pkg::sat_sum(tmp - p_ext);
  assign term     = hab4_pkg::ab4_coef(cidx) * hist[cidx];

  // Stiffness rises only strictly above the threshold.
  assign above      = (absang > DW'(regs.angle_threshold));
  assign ang_excess = signed'((DW+1)'(absang) - (DW+1)'(regs.angle_threshold));

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_div   = 1'b0;
    mul_state = 1'b1;
    case (state)
      S_H24: begin
        mul_a   = AW'((DW'(regs.step_size) + DW'(12)) >> 3);
        mul_b   = hab4_pkg::DIV3_MAGIC;
        mul_div = 1'b1;
      end
      S_AB: begin
        mul_a = combo;
        mul_b = h24;
      end
      S_FA: begin
        mul_a = AW'(vel);
        mul_b = BW'(regs.coupling_over_cap);
      end
      S_FB: begin
        mul_a = AW'(volt);
        mul_b = BW'(regs.inv_rc);
      end
      S_EU: begin
        mul_a = AW'(fval);
        mul_b = BW'(regs.step_size);
      end
      S_KLY: begin
        mul_a = AW'(pos);
        mul_b = BW'(regs.linear_stiffness);
      end
      S_FC: begin
        mul_a = AW'(volt);
        mul_b = BW'(regs.coupling_over_length);
      end
      S_KT: begin
        mul_a     = AW'(ang_excess);
        mul_b     = BW'(regs.torsion_slope);
        mul_state = above;
      end
      S_MT: begin
        mul_a = AW'(ang);
        mul_b = kt;
      end
      S_MK: begin
        mul_a = AW'(K0225);
        mul_b = kly;
      end
      default: mul_state = 1'b0;
    endcase
    mul_req.start    = mul_state && !issued;
    mul_req.div_mode = mul_div;
  end

  // Sequencer and integrator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      phase     <= '0;
      volt      <= '0;
      hist      <= '{default: '0};
      cidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (mul_req.start) begin
        issued <= 1'b1;
      end else if (mul_done) begin
        issued <= 1'b0;
      end

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (load.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (motion.valid) begin
            if (phase != hab4_pkg::PHASE_AB) phase <= phase + 1'b1;
            if (phase == PH'(0)) begin
              volt    <= '0;
              hist[0] <= '0;
              state   <= S_KLY;
            end else if (phase == hab4_pkg::PHASE_AB) begin
              state <= S_H24;
            end else begin
              state <= S_FA;
            end
          end
        end
        S_H24: begin
          if (mul_done) begin
            cidx  <= '0;
            state <= S_COMBO;
          end
        end
        S_COMBO: begin
          cidx <= cidx + 1'b1;
          if (cidx == HW'(HD - 1)) state <= S_AB;
        end
        S_AB: begin
          if (mul_done) begin
            volt <= volt_sum;
            for (int i = 0; i < HD - 1; i++) begin
              hist[i] <= hist[i+1];
            end
            state <= S_FA;
          end
        end
        S_FA: if (mul_done) state <= S_FB;
        S_FB: begin
          if (mul_done) begin
            hist[fidx] <= f_new;
            state      <= ab_mode ? S_KLY : S_EU;
          end
        end
        S_EU: begin
          if (mul_done) begin
            volt  <= volt_sum;
            state <= S_KLY;
          end
        end
        S_KLY: if (mul_done) state <= S_FC;
        S_FC:  if (mul_done) state <= S_KT;
        S_KT:  if (!above || mul_done) state <= S_MT;
        S_MT:  if (mul_done) state <= S_MK;
        S_MK:  if (mul_done) state <= S_DONE;
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working values and output payload.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (motion.valid) begin
          vel     <= motion.velocity_y;
          pos     <= motion.position_y;
          ang     <= motion.angle_z;
          absang  <= motion.angle_z[DW-1] ? DW'(-motion.angle_z) : DW'(motion.angle_z);
          ab_mode <= (phase == hab4_pkg::PHASE_AB);
          fidx    <= (phase == hab4_pkg::PHASE_AB) ? HW'(HD - 1) : phase[HW-1:0];
        end
      end
      S_H24: begin
        if (mul_done) begin
          h24   <= BW'(mul_rsp.result);
          combo <= '0;
        end
      end
      S_COMBO: combo <= combo + term;
      S_FA:    if (mul_done) tmp <= -p_ext;
      S_FB:    if (mul_done) fval <= f_new;
      S_KLY:   if (mul_done) kly <= mul_rsp.result;
      S_FC: begin
        if (mul_done) force_val <= hab4_pkg::sat_sum(p_ext - SW'(kly));
      end
      S_KT: begin
        if (!above) begin
          kt <= DW'(regs.torsion_base);
        end else if (mul_done) begin
          kt <= hab4_pkg::sat_sum(signed'(SW'(regs.torsion_base)) + p_ext);
        end
      end
      S_MT:    if (mul_done) tmp <= -p_ext;
      S_MK:    if (mul_done) moment_val <= hab4_pkg::sat_sum(tmp + p_ext);
      S_DONE: begin
        if (out_free) begin
          out_force   <= force_val;
          out_moment  <= moment_val;
          out_voltage <= volt;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/hab4_cfg.sv
// Configuration register file of the harvester load step.
`timescale 1ns / 1ps

module hab4_cfg (
  input  logic                clk,
  input  logic                rst,
  hab4_cfg_if.sink            cfg,
  output hab4_pkg::cfg_regs_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.coupling_over_cap    <= hab4_pkg::RST_COUPLING_OVER_CAP;
      regs.inv_rc               <= hab4_pkg::RST_INV_RC;
      regs.step_size            <= hab4_pkg::RST_STEP_SIZE;
      regs.coupling_over_length <= hab4_pkg::RST_COUPLING_OVER_LENGTH;
      regs.linear_stiffness     <= hab4_pkg::RST_LINEAR_STIFFNESS;
      regs.torsion_base         <= hab4_pkg::RST_TORSION_BASE;
      regs.torsion_slope        <= hab4_pkg::RST_TORSION_SLOPE;
      regs.angle_threshold      <= hab4_pkg::RST_ANGLE_THRESHOLD;
    end else if (cfg.valid) begin
      case (cfg.index)
        hab4_pkg::CFG_COUPLING_OVER_CAP:    regs.coupling_over_cap    <= cfg.data;
        hab4_pkg::CFG_INV_RC:               regs.inv_rc               <= cfg.data;
        hab4_pkg::CFG_STEP_SIZE:            regs.step_size            <= cfg.data;
        hab4_pkg::CFG_COUPLING_OVER_LENGTH: regs.coupling_over_length <= cfg.data;
        hab4_pkg::CFG_LINEAR_STIFFNESS:     regs.linear_stiffness     <= cfg.data;
        hab4_pkg::CFG_TORSION_BASE:         regs.torsion_base         <= cfg.data;
        hab4_pkg::CFG_TORSION_SLOPE:        regs.torsion_slope        <= cfg.data;
        hab4_pkg::CFG_ANGLE_THRESHOLD:      regs.angle_threshold      <= cfg.data;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

endmodule

// File: rtl/core/hab4_mul.sv
// Shared digit-serial fixed-point multiplier with rounding and saturation.
`timescale 1ns / 1ps

module hab4_mul #(
  parameter int FRAC_BITS = hab4_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  hab4_pkg::mul_req_t                   req,
  input  logic signed [hab4_pkg::MUL_A_W-1:0]  a,
  input  logic signed [hab4_pkg::MUL_B_W-1:0]  b,
  output hab4_pkg::mul_rsp_t                   rsp
);

  localparam int AW = hab4_pkg::MUL_A_W;
  localparam int BW = hab4_pkg::MUL_B_W;
  localparam int DW = hab4_pkg::MUL_DIG_W;
  localparam int PW = hab4_pkg::MUL_P_W;
  localparam int CW = hab4_pkg::DIG_CNT_W;
  localparam int OW = hab4_pkg::DATA_W;

  localparam logic signed [PW-1:0] ROUND   = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] SAT_MAX = {{(PW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_MIN = {{(PW-OW+1){1'b1}}, {(OW-1){1'b0}}};

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_ACC  = 3'b010,
    M_FIN  = 3'b100
  } mstate_t;

  mstate_t                state;
  logic signed [AW-1:0]   a_reg;
  logic        [BW-1:0]   b_sh;
  logic signed [PW-1:0]   acc;
  logic                   div_reg;
  logic        [CW-1:0]   cnt;

  logic                   last_dig;
  logic signed [DW:0]     digit;
  logic signed [AW+DW:0]  pp;
  logic signed [PW-1:0]   pp_sh;
  logic signed [PW-1:0]   rounded;
  logic signed [PW-1:0]   shifted;

  // Low digits are unsigned, the top digit carries the sign of B.
  assign last_dig = (cnt == CW'(hab4_pkg::MUL_DIGITS - 1));
  assign digit    = {last_dig & b_sh[DW-1], b_sh[DW-1:0]};
  assign pp       = a_reg * digit;
  assign pp_sh    = PW'(pp) <<< (DW * cnt);

  assign rounded  = acc + ROUND;
  assign shifted  = div_reg ? (acc >>> hab4_pkg::DIV_SHIFT) : (rounded >>> FRAC_BITS);

  always_comb begin
    rsp.done = (state == M_FIN);
    if (!div_reg && shifted > SAT_MAX) begin
      rsp.result = SAT_MAX[OW-1:0];
    end else if (!div_reg && shifted < SAT_MIN) begin
      rsp.result = SAT_MIN[OW-1:0];
    end else begin
      rsp.result = shifted[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        M_IDLE: begin
          cnt <= '0;
          if (req.start) state <= M_ACC;
        end
        M_ACC: begin
          cnt <= cnt + 1'b1;
          if (last_dig) state <= M_FIN;
        end
        M_FIN: state <= M_IDLE;
        default: state <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (req.start) begin
          a_reg   <= a;
          b_sh    <= b;
          div_reg <= req.div_mode;
          acc     <= '0;
        end
      end
      M_ACC: begin
        acc  <= acc + pp_sh;
        b_sh <= b_sh >> DW;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/hab4_checker.sv
// Port-level checker for the harvester load step, bound to the top level.
`timescale 1ns / 1ps

module hab4_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [hab4_pkg::DATA_W-1:0] force_y,
  input logic signed [hab4_pkg::DATA_W-1:0] moment_z,
  input logic signed [hab4_pkg::DATA_W-1:0] voltage
);

  logic [1:0] outstanding;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // Count beats taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_beat && !out_beat) begin
      outstanding <= outstanding + 1'b1;
    end else if (out_beat && !in_beat) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !in_ready)
    else $error("motion ready right after an accepted beat");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != 2'd0)
    else $error("load beat offered with no motion beat pending");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> outstanding <= 2'd1)
    else $error("ready while a beat is still in work");

  a_load_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(force_y) && $stable(moment_z)
      && $stable(voltage))
    else $error("stalled load beat changed");

endmodule

bind harvester_ab4_load_step hab4_checker u_hab4_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (motion.valid),
  .in_ready  (motion.ready),
  .out_valid (load.valid),
  .out_ready (load.ready),
  .force_y   (load.force_y),
  .moment_z  (load.moment_z),
  .voltage   (load.voltage)
);
